// File: hdl/pfrag_pkg.sv
// pfrag_pkg: shared types and constants of the packet fragmenter
// no dependencies

package pfrag_pkg;

	localparam int unsigned HDR_BYTES = 6;
	localparam logic [15:0] USABLE_RESET = 16'd1024;
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// byte positions inside one command
	localparam logic [2:0] POS_SEQ_LO   = 3'd0;
	localparam logic [2:0] POS_SEQ_HI   = 3'd1;
	localparam logic [2:0] POS_IDX_LO   = 3'd2;
	localparam logic [2:0] POS_IDX_HI   = 3'd3;
	localparam logic [2:0] POS_TOT_LO   = 3'd4;
	localparam logic [2:0] POS_TOT_HI   = 3'd5;
	localparam logic [2:0] POS_PAYLOAD  = 3'd6;

	typedef struct packed {
		logic [15:0] seq;
		logic [15:0] idx;
		logic [15:0] total;
		logic [7:0]  data;
		logic        hdr;
		logic        payload;
		logic        fend;
		logic        pend;
	} cmd_t;

endpackage

// File: hdl/pfrag_div.sv
// pfrag_div: restoring divider, one quotient bit per cycle
// depends on pfrag_pkg

module pfrag_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quotient
);

	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] div_q;
	logic [pfrag_pkg::DIV_CNT_W-1:0] cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] shifted;
	logic        ge;
	logic [16:0] diff;

	assign shifted = {rem_q, quo_q[15]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pfrag_pkg::DIV_CNT_W'(pfrag_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : shifted[15:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hdl/pfrag_front.sv
// pfrag_front: accepts input bytes, tracks packet and fragment state, builds commands
// depends on pfrag_pkg and pfrag_div

module pfrag_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_data,
	input  logic [15:0]       in_len,
	input  logic              in_last,
	input  logic [15:0]       use_bytes,
	output logic              push,
	output pfrag_pkg::cmd_t   cmd,
	input  logic              q_full
);

	localparam logic [1:0] ST_IN   = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]  state_q;
	logic [7:0]  data_q;
	logic [15:0] len_q;
	logic        last_q;
	logic        start_q;
	logic        inside_q;
	logic [15:0] seq_q;
	logic [15:0] idx_q;
	logic [15:0] total_q;
	logic [15:0] bif_q;
	logic [15:0] bip_q;

	logic        accept;
	logic        div_start;
	logic [15:0] dividend;
	logic        div_done;
	logic [15:0] div_quo;

	logic [15:0] cur_total;
	logic [15:0] cur_idx;
	logic [15:0] cur_bif;
	logic [15:0] cur_bip;
	logic        empty;
	logic        pend;
	logic        fend;

	assign in_ready  = (state_q == ST_IN);
	assign accept    = in_valid && in_ready;
	assign div_start = accept && !inside_q;
	assign dividend  = (in_len == 16'd0) ? 16'd0 : in_len - 16'd1;

	pfrag_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (use_bytes),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		cur_total = start_q ? div_quo + 16'd1 : total_q;
		cur_idx   = start_q ? 16'd0 : idx_q;
		cur_bif   = start_q ? 16'd0 : bif_q;
		cur_bip   = start_q ? 16'd0 : bip_q;
		empty     = start_q && (len_q == 16'd0);
		pend      = empty || last_q || (({1'b0, cur_bip} + 17'd1) >= {1'b0, len_q});
		fend      = pend || (({1'b0, cur_bif} + 17'd1) >= {1'b0, use_bytes});
		cmd.seq     = seq_q;
		cmd.idx     = cur_idx;
		cmd.total   = cur_total;
		cmd.data    = data_q;
		cmd.hdr     = (cur_bif == 16'd0);
		cmd.payload = !empty;
		cmd.fend    = fend;
		cmd.pend    = pend;
	end

	assign push = (state_q == ST_PUSH) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IN;
			inside_q <= 1'b0;
			seq_q    <= '0;
			idx_q    <= '0;
			total_q  <= '0;
			bif_q    <= '0;
			bip_q    <= '0;
			start_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IN: begin
					if (accept) begin
						start_q <= !inside_q;
						state_q <= inside_q ? ST_PUSH : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push) begin
						state_q <= ST_IN;
						total_q <= cur_total;
						if (pend) begin
							seq_q    <= seq_q + 16'd1;
							idx_q    <= '0;
							bif_q    <= '0;
							bip_q    <= '0;
							inside_q <= 1'b0;
						end else begin
							inside_q <= 1'b1;
							bip_q    <= cur_bip + 16'd1;
							if (fend) begin
								bif_q <= '0;
								idx_q <= cur_idx + 16'd1;
							end else begin
								bif_q <= cur_bif + 16'd1;
								idx_q <= cur_idx;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= in_data;
			len_q  <= in_len;
			last_q <= in_last;
		end
	end

endmodule

// File: hdl/pfrag_fifo.sv
// pfrag_fifo: command queue between front and back, registered read
// depends on pfrag_pkg

module pfrag_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pfrag_pkg::cmd_t push_data,
	output logic            full,
	output logic            out_valid,
	input  logic            pop,
	output pfrag_pkg::cmd_t out_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	pfrag_pkg::cmd_t mem [DEPTH];
	pfrag_pkg::cmd_t out_q;
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            ov_q;
	logic            do_push;
	logic            fetch;

	assign full    = (cnt_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign fetch   = (cnt_q != '0) && (!ov_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (fetch) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(fetch);
			if (fetch) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (fetch) begin
			out_q <= mem[rd_ptr_q];
		end
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

endmodule

// File: hdl/pfrag_back.sv
// pfrag_back: turns commands into header and payload bytes on the output stream
// depends on pfrag_pkg

module pfrag_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_pop,
	input  pfrag_pkg::cmd_t cmd_in,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic [2:0]      m_tuser,
	output logic            m_tlast
);

	pfrag_pkg::cmd_t cmd_q;
	logic [2:0]      pos_q;
	logic            busy_q;
	logic            ov_q;
	logic [7:0]      byte_q;
	logic [2:0]      user_q;
	logic            last_q;

	logic            out_free;
	logic            emit;
	logic            cmd_done;
	logic [7:0]      cur_byte;
	logic            is_hdr;
	logic            f_end;
	logic            p_end;
	logic            r_last;

	assign out_free = !ov_q || m_tready;
	assign emit     = busy_q && out_free;
	assign cmd_pop  = cmd_valid && !busy_q;
	assign cmd_done = (pos_q == pfrag_pkg::POS_PAYLOAD) ||
		((pos_q == pfrag_pkg::POS_TOT_HI) && !cmd_q.payload);

	always_comb begin
		unique case (pos_q)
			pfrag_pkg::POS_SEQ_LO:  cur_byte = cmd_q.seq[7:0];
			pfrag_pkg::POS_SEQ_HI:  cur_byte = cmd_q.seq[15:8];
			pfrag_pkg::POS_IDX_LO:  cur_byte = cmd_q.idx[7:0];
			pfrag_pkg::POS_IDX_HI:  cur_byte = cmd_q.idx[15:8];
			pfrag_pkg::POS_TOT_LO:  cur_byte = cmd_q.total[7:0];
			pfrag_pkg::POS_TOT_HI:  cur_byte = cmd_q.total[15:8];
			default:                cur_byte = cmd_q.data;
		endcase
		is_hdr = (pos_q != pfrag_pkg::POS_PAYLOAD);
		if (pos_q == pfrag_pkg::POS_PAYLOAD) begin
			f_end  = cmd_q.fend;
			p_end  = cmd_q.pend;
			r_last = 1'b1;
		end else begin
			f_end  = cmd_done;
			p_end  = cmd_done;
			r_last = cmd_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (out_free) begin
				ov_q <= busy_q;
			end
			if (cmd_pop) begin
				busy_q <= 1'b1;
				pos_q  <= cmd_in.hdr ? pfrag_pkg::POS_SEQ_LO : pfrag_pkg::POS_PAYLOAD;
			end else if (emit) begin
				if (cmd_done) begin
					busy_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_in;
		end
		if (emit) begin
			byte_q <= cur_byte;
			user_q <= {r_last, f_end, is_hdr};
			last_q <= p_end;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = byte_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule

// File: hdl/packet_fragmenter_core.sv
// packet_fragmenter_core: top level of the packet fragmenter
// depends on pfrag_pkg, pfrag_front, pfrag_fifo, pfrag_back
//
// Splits packets arriving one byte per transaction into fragments, each a 6-byte
// little-endian header {sequence, fragment index, fragment count} followed by up to
// usable_bytes payload bytes (a value of 0 acts as 1). The front end takes a new byte
// once the command of the last is queued; the first byte of a packet also waits for
// the fragment count, worked out by a 16-step serial divider. A command queue of
// QUEUE_DEPTH entries plus one output register feeds the back end, which sends one
// byte per cycle while m_tready does not stall it and takes a new command only when
// done with the last. usable_bytes may be changed only while the block is idle.

module packet_fragmenter_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,   // usable_bytes
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,       // data_byte[7:0], packet_length[23:8]
	input  logic        s_tlast,       // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,       // out_byte[7:0]
	output logic [2:0]  m_tuser,       // is_header[0], fragment_end[1], run_last[2]
	output logic        m_tlast        // packet_end
);

	logic [15:0]     usable_q;
	logic [15:0]     use_bytes;
	logic            push;
	logic            q_full;
	logic            q_valid;
	logic            q_pop;
	pfrag_pkg::cmd_t push_cmd;
	pfrag_pkg::cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= pfrag_pkg::USABLE_RESET;
		end else if (cfg_wr_en) begin
			usable_q <= cfg_wr_data;
		end
	end

	assign use_bytes = (usable_q == 16'd0) ? 16'd1 : usable_q;

	pfrag_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata[7:0]),
		.in_len    (s_tdata[23:8]),
		.in_last   (s_tlast),
		.use_bytes (use_bytes),
		.push      (push),
		.cmd       (push_cmd),
		.q_full    (q_full)
	);

	pfrag_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (q_full),
		.out_valid (q_valid),
		.pop       (q_pop),
		.out_data  (q_cmd)
	);

	pfrag_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd_in    (q_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: hdl/pfrag_checker.sv
// pfrag_checker: port-level checks of the packet fragmenter output stream
// bound to packet_fragmenter_core; no other dependencies

module pfrag_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);

	// stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

	// packet end closes the fragment and the run
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1] && m_tuser[2])
		else $error("packet end without fragment end or run end");

	// a fragment ends inside a header only for an empty packet
	a_hdr_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tuser[1] |-> m_tlast && m_tuser[2])
		else $error("header-only fragment not closing the packet");

	// every payload byte closes its run
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tuser[2])
		else $error("payload byte without run end");

endmodule

bind packet_fragmenter_core pfrag_checker u_pfrag_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
